// ===== sv/yuvrgb_pkg.sv =====
package yuvrgb_pkg;

  // default sizing of the line store and counters
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // configuration registers
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // word layout
  localparam int PIX_W     = 8;
  localparam int IDX_W     = 22;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // q16 arithmetic
  localparam int ACC_W  = 27;
  localparam int COEF_W = 18;
  localparam logic signed [COEF_W-1:0] K_RV = 18'sd91881;
  localparam logic signed [COEF_W-1:0] K_GU = 18'sd22554;
  localparam logic signed [COEF_W-1:0] K_GV = 18'sd46802;
  localparam logic signed [COEF_W-1:0] K_BU = 18'sd116130;
  localparam logic signed [8:0]        CHROMA_MID = 9'sd128;

  // floor of acc / 65536, clamped to 0..255
  function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-17:0] q;
    logic [PIX_W-1:0]         res;
    q = acc[ACC_W-1:16];
    if (q < 0) begin
      res = '0;
    end else if (q > 255) begin
      res = '1;
    end else begin
      res = q[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/yuv420_to_rgb_converter.sv =====
// channel   | direction | tdata / payload (lsb first)                 | side band
// ----------+-----------+---------------------------------------------+-----------------
// in_       | slave     | luma[7:0] chroma_u[15:8] chroma_v[23:16]    | -
// out_      | master    | blue green red pixel_index[45:24] pad[47:46] | tlast = frame_end
// cfg_      | slave     | cfg_addr = register index, cfg_data[11:0]    | cfg_ready always 1
//
// one pixel word per clock sustained while out_tready holds; a word passes the stage 1,
// stage 2 and stage 3 registers before out_tvalid rises for it
// stage 1 holds the line store read data, stage 2 the multiplier products,
// stage 3 the clamped output register
// stalls on out_tready ripple back combinationally; empty stages are filled at once
// rst_n (synchronous) clears counters and stage valids and loads the size registers with defaults;
// the chroma line store is not cleared and needs no pass after reset
module yuv420_to_rgb_converter #(
  parameter int MAX_WIDTH  = yuvrgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = yuvrgb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // luma[7:0], chroma_u[15:8], chroma_v[23:16]
  input  logic [yuvrgb_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // blue[7:0], green[15:8], red[23:16], pixel_index[45:24], zero[47:46]
  output logic [yuvrgb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [yuvrgb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import yuvrgb_pkg::*;

  localparam int PAIRS = MAX_WIDTH / 2;
  localparam int CW = (MAX_WIDTH > 2)  ? $clog2(MAX_WIDTH)  : 1;  // column counter
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;  // row counter
  localparam int WW = $clog2(MAX_WIDTH + 1);                      // effective width
  localparam int HW = $clog2(MAX_HEIGHT + 1);                     // effective height
  localparam int AW = (PAIRS > 1) ? $clog2(PAIRS) : 1;            // line store address
  localparam int PW = WW + HW;                                    // row offset product

  // ---------------- configuration registers ----------------
  logic [CFG_DATA_W-1:0] width_cfg_r, height_cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= FRAME_WIDTH_RST;
      height_cfg_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:  width_cfg_r  <= cfg_data;
        CFG_FRAME_HEIGHT: height_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size: width clipped to 2..MAX_WIDTH and made even,
  // height clipped to 1..MAX_HEIGHT
  logic [WW-1:0] w_eff, w_clip;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (width_cfg_r < 2) begin
      w_clip = WW'(2);
    end else if (width_cfg_r > MAX_WIDTH) begin
      w_clip = WW'(MAX_WIDTH);
    end else begin
      w_clip = WW'(width_cfg_r);
    end
    w_eff = {w_clip[WW-1:1], 1'b0};

    if (height_cfg_r == '0) begin
      h_eff = HW'(1);
    end else if (height_cfg_r > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_cfg_r);
    end
  end

  // ---------------- pipeline control ----------------
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic accept;

  assign en3       = !v3_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign accept    = in_tvalid && in_tready;

  // ---------------- raster counters ----------------
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          last_pix;
  logic          chroma_wr;
  logic [AW-1:0] pair_addr;

  always_comb begin
    // a counter beyond a freshly shrunk size restarts at zero
    col_cur = (col_r >= w_eff) ? '0 : col_r;
    row_cur = (row_r >= h_eff) ? '0 : row_r;
    col_inc = {1'b0, col_cur} + 1'b1;
    row_inc = {1'b0, row_cur} + 1'b1;
    last_pix = 1'b0;
    col_nxt  = col_inc[CW-1:0];
    row_nxt  = row_cur;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_inc[RW-1:0];
      if (row_inc >= h_eff) begin
        row_nxt  = '0;
        last_pix = 1'b1;
      end
    end
    chroma_wr = !col_cur[0] && !row_cur[0];
    pair_addr = AW'(col_cur >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- chroma line store ----------------
  // u in the high byte, v in the low byte; a write and the read of the same
  // pixel hit the same entry, so that pixel takes its chroma from the input
  logic [2*PIX_W-1:0] chroma_mem [PAIRS];
  logic [2*PIX_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (chroma_wr) begin
        chroma_mem[pair_addr] <= {in_tdata[15:8], in_tdata[23:16]};
      end
      rd_r <= chroma_mem[pair_addr];
    end
  end

  // ---------------- stage 1: operand capture ----------------
  logic [PIX_W-1:0] y1_r, u1_r, v1d_r;
  logic             fwd1_r, last1_r;
  logic [HW-1:0]    hrem1_r;
  logic [WW-1:0]    w1_r;
  logic [CW-1:0]    col1_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      y1_r    <= in_tdata[7:0];
      u1_r    <= in_tdata[15:8];
      v1d_r   <= in_tdata[23:16];
      fwd1_r  <= chroma_wr;
      last1_r <= last_pix;
      hrem1_r <= h_eff - HW'(1) - HW'(row_cur);
      w1_r    <= w_eff;
      col1_r  <= col_cur;
    end
  end

  logic [PIX_W-1:0]  u_sel, v_sel;
  logic signed [8:0] du, dv;

  always_comb begin
    u_sel = fwd1_r ? u1_r  : rd_r[15:8];
    v_sel = fwd1_r ? v1d_r : rd_r[7:0];
    du    = $signed({1'b0, u_sel}) - CHROMA_MID;
    dv    = $signed({1'b0, v_sel}) - CHROMA_MID;
  end

  // ---------------- stage 2: products ----------------
  logic signed [ACC_W-1:0] ys2_r, pbu2_r, pgu2_r, pgv2_r, prv2_r;
  logic [PW-1:0]           prod2_r;
  logic [CW-1:0]           col2_r;
  logic                    last2_r;

  always_ff @(posedge clk) begin
    if (v1_r && en2) begin
      ys2_r   <= $signed({3'b000, y1_r, 16'h0000});
      pbu2_r  <= K_BU * du;
      pgu2_r  <= K_GU * du;
      pgv2_r  <= K_GV * dv;
      prv2_r  <= K_RV * dv;
      prod2_r <= PW'(hrem1_r) * PW'(w1_r);
      col2_r  <= col1_r;
      last2_r <= last1_r;
    end
  end

  // ---------------- stage 3: sums, clamp, output register ----------------
  logic signed [ACC_W-1:0] acc_b, acc_g, acc_r;
  logic [IDX_W-1:0]        idx_sum;

  always_comb begin
    acc_b   = ys2_r + pbu2_r;
    acc_g   = ys2_r - pgu2_r - pgv2_r;
    acc_r   = ys2_r + prv2_r;
    idx_sum = IDX_W'({1'b0, prod2_r} + (PW + 1)'(col2_r));
  end

  logic [PIX_W-1:0] blue_r, green_r, red_r;
  logic [IDX_W-1:0] idx_r;
  logic             last3_r;

  always_ff @(posedge clk) begin
    if (v2_r && en3) begin
      blue_r  <= clamp_q16(acc_b);
      green_r <= clamp_q16(acc_g);
      red_r   <= clamp_q16(acc_r);
      idx_r   <= idx_sum;
      last3_r <= last2_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= accept;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tlast  = last3_r;
  assign out_tdata  = {(OUT_DATA_W - IDX_W - 3 * PIX_W)'(0), idx_r, red_r, green_r, blue_r};

`ifndef SYNTHESIS
  // counters stay inside the frame after each accepted word
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (col_r < $past(w_eff)))
    else $error("column counter beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (row_r < $past(h_eff)))
    else $error("row counter beyond frame height");

  // the last pixel of a frame wraps both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_pix) |=> (col_r == '0 && row_r == '0))
    else $error("counters not wrapped at frame end");

  // input is held off only when every stage is full and the output stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && !out_tready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== test/yuv420_to_rgb_converter_tb.sv =====
module yuv420_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import yuvrgb_pkg::*;

  // q16 conversion coefficients, full-range bt.601
  localparam int Q_R_FROM_V = 91881;
  localparam int Q_G_FROM_U = 22554;
  localparam int Q_G_FROM_V = 46802;
  localparam int Q_B_FROM_U = 116130;
  localparam int MAX_W      = DEF_MAX_WIDTH;
  localparam int MAX_H      = DEF_MAX_HEIGHT;
  localparam int LINE_PAIRS = DEF_MAX_WIDTH / 2;

  localparam int RANDOM_PIXELS   = 500;
  localparam int LARGE_PIXELS    = 32;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 12;

  // one expected rgb word
  typedef struct {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [IDX_W-1:0] pix_index;
    logic             frame_end;
  } rgb_word_t;

  // one row of the directed sequence: a register write or a pixel word
  typedef struct {
    bit                    is_write;
    logic [CFG_ADDR_W-1:0] sel;
    logic [CFG_DATA_W-1:0] val;
    logic [7:0]            y;
    logic [7:0]            u;
    logic [7:0]            v;
    bit                    typed;
    logic [7:0]            b;
    logic [7:0]            g;
    logic [7:0]            r;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  yuv420_to_rgb_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // rgb words the converter still owes, oldest first
  rgb_word_t rgb_pending[$];
  dir_row_t  dir_rows[$];
  int        fail_count = 0;

  // idling controls for the sender and the receiver
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_off_req = 1'b0;

  // predictor state: size registers, raster position and the chroma line store
  logic [CFG_DATA_W-1:0] size_w_reg = FRAME_WIDTH_RST;
  logic [CFG_DATA_W-1:0] size_h_reg = FRAME_HEIGHT_RST;
  int                    pos_col = 0;
  int                    pos_row = 0;
  logic [7:0]            line_u[LINE_PAIRS];
  logic [7:0]            line_v[LINE_PAIRS];
  bit                    line_written[LINE_PAIRS];

  initial begin
    forever #5 clk = ~clk;
  end

  // timeout guard
  initial begin
    #20_000_000;
    $display("yuv420_to_rgb_converter verification failed");
    $finish;
  end

  // sizes as the converter uses them: width clamped and forced even, height clamped
  function automatic int eff_width(logic [CFG_DATA_W-1:0] raw);
    int w;
    w = raw;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    return w & ~1;
  endfunction

  function automatic int eff_height(logic [CFG_DATA_W-1:0] raw);
    int h;
    h = raw;
    if (h < 1) h = 1;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  // floor of a q16 sum, saturated to a byte
  function automatic logic [7:0] sat_q16(int acc);
    int q;
    q = acc >>> 16;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // advance the predictor by one pixel and return the rgb word it owes
  function automatic rgb_word_t predict_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
    rgb_word_t want;
    int        w;
    int        h;
    int        pair;
    int        ys;
    int        du;
    int        dv;
    int        idx;
    w = eff_width(size_w_reg);
    h = eff_height(size_h_reg);
    // a size change can leave a counter past the end of the new frame
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    pair = pos_col >> 1;
    // chroma is captured only on even rows at even columns
    if (pos_row % 2 == 0 && pos_col % 2 == 0) begin
      line_u[pair] = u;
      line_v[pair] = v;
      line_written[pair] = 1'b1;
    end
    ys = int'(y) * 65536;
    du = int'(line_u[pair]) - 128;
    dv = int'(line_v[pair]) - 128;
    want.blue  = sat_q16(ys + Q_B_FROM_U * du);
    want.green = sat_q16(ys - Q_G_FROM_U * du - Q_G_FROM_V * dv);
    want.red   = sat_q16(ys + Q_R_FROM_V * dv);
    // output rows are flipped top to bottom
    idx = (h - 1 - pos_row) * w + pos_col;
    want.pix_index = idx[IDX_W-1:0];
    want.frame_end = 1'b0;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) begin
        pos_row = 0;
        want.frame_end = 1'b1;
      end
    end
    return want;
  endfunction

  // new sizes are allowed only if the rest of the current row reads written chroma
  function automatic bit sizes_fit(logic [CFG_DATA_W-1:0] nw, logic [CFG_DATA_W-1:0] nh);
    int w;
    int h;
    int c;
    int r;
    w = eff_width(nw);
    h = eff_height(nh);
    c = (pos_col < w) ? pos_col : 0;
    r = (pos_row < h) ? pos_row : 0;
    if (r % 2 == 1) begin
      for (int p = c / 2; p < w / 2; p++) begin
        if (!line_written[p]) return 1'b0;
      end
    end else if (c % 2 == 1 && !line_written[c / 2]) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // pixels left until the end of the current frame
  function automatic int pixels_to_frame_end();
    int w;
    int h;
    int c;
    int r;
    w = eff_width(size_w_reg);
    h = eff_height(size_h_reg);
    c = (pos_col < w) ? pos_col : 0;
    r = (pos_row < h) ? pos_row : 0;
    return w * h - (r * w + c);
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int gap_cycles(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sample value with extra weight on the extremes and mid-scale
  function automatic logic [7:0] sample8();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd255;
    if (r < 38) return 8'd128;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return CFG_DATA_W'(2 * $urandom_range(1, 16));
    if (r < 77) return CFG_DATA_W'(2 * $urandom_range(1, 20) + 1);
    if (r < 83) return CFG_DATA_W'($urandom_range(0, 1));
    if (r < 92) return CFG_DATA_W'($urandom_range(2, MAX_W));
    return CFG_DATA_W'($urandom_range(MAX_W + 1, 4095));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return CFG_DATA_W'($urandom_range(1, 8));
    if (r < 75) return '0;
    if (r < 88) return CFG_DATA_W'($urandom_range(9, 64));
    if (r < 95) return CFG_DATA_W'($urandom_range(65, MAX_H));
    return CFG_DATA_W'($urandom_range(MAX_H + 1, 4095));
  endfunction

  function automatic void push_px(logic [7:0] y, logic [7:0] u, logic [7:0] v);
    dir_row_t row;
    row = '{default: '0};
    row.y = y;
    row.u = u;
    row.v = v;
    dir_rows.push_back(row);
  endfunction

  function automatic void push_typed(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                     logic [7:0] b, logic [7:0] g, logic [7:0] r);
    dir_row_t row;
    row = '{default: '0};
    row.y = y;
    row.u = u;
    row.v = v;
    row.typed = 1'b1;
    row.b = b;
    row.g = g;
    row.r = r;
    dir_rows.push_back(row);
  endfunction

  function automatic void push_write(logic [CFG_ADDR_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.sel = sel;
    row.val = val;
    dir_rows.push_back(row);
  endfunction

  // offer one pixel word; called and left at a falling edge
  task automatic send_pixel(input logic [7:0] y, input logic [7:0] u, input logic [7:0] v,
                            input bit typed, input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r);
    int        gap;
    rgb_word_t want;
    gap = gap_cycles(sender_gaps);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, u, y};
    do @(posedge clk); while (!in_tready);
    want = predict_pixel(y, u, v);
    // directed rows with colors read straight off the formula
    if (typed) begin
      want.blue  = b;
      want.green = g;
      want.red   = r;
    end
    rgb_pending.push_back(want);
    @(negedge clk);
  endtask

  // register write once the pipeline has drained
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    wait (rgb_pending.size() == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (sel == CFG_FRAME_WIDTH) size_w_reg = val;
    else size_h_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // new frame size at random, only where no unwritten chroma would be read
  task automatic pick_sizes();
    int                    which;
    logic [CFG_DATA_W-1:0] nw;
    logic [CFG_DATA_W-1:0] nh;
    bit                    ok;
    which = $urandom_range(0, 2);
    ok = 1'b0;
    for (int t = 0; t < 20 && !ok; t++) begin
      nw = (which != 1) ? rand_width() : size_w_reg;
      nh = (which != 0) ? rand_height() : size_h_reg;
      ok = sizes_fit(nw, nh);
    end
    if (ok) begin
      if (which != 1) write_reg(CFG_FRAME_WIDTH, nw);
      if (which != 0) write_reg(CFG_FRAME_HEIGHT, nh);
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = gap_cycles(receiver_stalls);
      end
    end
  end

  // result checker: every accepted rgb word against the oldest expectation
  always @(posedge clk) begin : out_monitor
    rgb_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rgb_pending.size() == 0) begin
        $display("%0t ns: unexpected rgb word, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = rgb_pending.pop_front();
        check_field("blue", want.blue, out_tdata[7:0]);
        check_field("green", want.green, out_tdata[15:8]);
        check_field("red", want.red, out_tdata[23:16]);
        check_field("pixel_index", want.pix_index, out_tdata[45:24]);
        check_field("frame_end", want.frame_end, out_tlast);
      end
    end
  end

  initial begin : stimulus
    int n;
    int left;
    bit first_phase;
    int random_px;

    foreach (line_written[i]) line_written[i] = 1'b0;

    // reset defaults, row 0 of a 640x480 frame
    push_typed(8'd0,   8'd128, 8'd128, 8'd0,   8'd0,   8'd0);
    // odd column: chroma fields ignored, grey pair reused
    push_typed(8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255);
    push_typed(8'd0,   8'd0,   8'd0,   8'd0,   8'd135, 8'd0);
    push_px(8'd255, 8'd255, 8'd255);
    push_typed(8'd255, 8'd255, 8'd255, 8'd255, 8'd120, 8'd255);
    push_px(8'd0, 8'd0, 8'd0);
    push_px(8'hAA, 8'h55, 8'hAA);
    push_px(8'h55, 8'hAA, 8'h55);
    // width below minimum mid-row: column 8 is past the new size and restarts
    push_write(CFG_FRAME_WIDTH, 12'd1);
    push_px(8'h80, 8'hFF, 8'h00);
    push_px(8'h7F, 8'h00, 8'hFF);
    push_px(8'hFE, 8'h01, 8'h80);
    push_px(8'h01, 8'hFE, 8'h7F);
    // zero height taken as one, row 2 restarts at the top
    push_write(CFG_FRAME_HEIGHT, 12'd0);
    push_px(8'hFF, 8'h00, 8'h00);
    push_px(8'h00, 8'h12, 8'h34);
    // odd width rounds down to even
    push_write(CFG_FRAME_WIDTH, 12'd3);
    push_px(8'h40, 8'hFF, 8'hFF);
    push_px(8'hC0, 8'h00, 8'h00);
    push_px(8'h00, 8'h00, 8'hFF);
    push_px(8'hFF, 8'hFF, 8'h00);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) begin
        write_reg(dir_rows[i].sel, dir_rows[i].val);
      end else begin
        send_pixel(dir_rows[i].y, dir_rows[i].u, dir_rows[i].v, dir_rows[i].typed,
                   dir_rows[i].b, dir_rows[i].g, dir_rows[i].r);
      end
    end

    // oversized registers clamp to the largest frame; the top row of it
    // carries indexes near the top of the range
    write_reg(CFG_FRAME_WIDTH, 12'hFFF);
    write_reg(CFG_FRAME_HEIGHT, 12'hFFF);
    repeat (LARGE_PIXELS) send_pixel(sample8(), sample8(), sample8(), 1'b0, '0, '0, '0);

    // random phases: sizes changed between phases, often mid-frame
    first_phase = 1'b1;
    random_px = 0;
    while (random_px < RANDOM_PIXELS) begin
      if (first_phase) begin
        // receiver holds off while the sender keeps offering, so the pipe backs up
        sender_gaps = 1'b0;
        receiver_stalls = 1'b1;
        hold_off_req = 1'b1;
        n = 80;
        first_phase = 1'b0;
      end else begin
        pick_sizes();
        sender_gaps = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
        left = pixels_to_frame_end();
        if ($urandom_range(0, 1) == 0 && left <= 256) n = left;
        else n = $urandom_range(1, 60);
      end
      if (n > RANDOM_PIXELS - random_px) n = RANDOM_PIXELS - random_px;
      repeat (n) begin
        send_pixel(sample8(), sample8(), sample8(), 1'b0, '0, '0, '0);
        random_px++;
      end
    end

    in_tvalid <= 1'b0;
    wait (rgb_pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("yuv420_to_rgb_converter verification clean");
    end else begin
      $display("yuv420_to_rgb_converter verification failed");
    end
    $finish;
  end

endmodule

// ===== yuv420_to_rgb_converter.f =====
sv/yuvrgb_pkg.sv
sv/yuv420_to_rgb_converter.sv
test/yuv420_to_rgb_converter_tb.sv
